/* hdl/rrp_pkg.sv */
// rrp_pkg: shared types, constants and phase codes for the resp request parser
// used by rrp_core, rrp_out_buf and resp_request_parser_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrp_pkg;

	localparam int COUNT_BITS   = 8;
	localparam int LENGTH_BITS  = 16;
	localparam int MSG_LEN_BITS = 24;
	localparam int ID_BITS      = 31;
	localparam int ARG_BITS     = 8;
	localparam int CFG_CNT_BITS = 8;
	localparam int CFG_LEN_BITS = 16;

	localparam int NUM_BITS_A = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
	localparam int NUM_BITS_B = (CFG_CNT_BITS > CFG_LEN_BITS) ? CFG_CNT_BITS : CFG_LEN_BITS;
	localparam int NUM_BITS   = (NUM_BITS_A > NUM_BITS_B) ? NUM_BITS_A : NUM_BITS_B;

	localparam logic [NUM_BITS-1:0] COUNT_MAX = NUM_BITS'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [NUM_BITS-1:0] LENGTH_MAX = NUM_BITS'((64'd1 << LENGTH_BITS) - 64'd1);
	localparam logic [MSG_LEN_BITS-1:0] MSG_LEN_MAX = {MSG_LEN_BITS{1'b1}};
	localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_ARG   = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic REG_MAX_COUNT  = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef enum logic [3:0] {
		PH_STAR     = 4'd0,
		PH_COUNT    = 4'd1,
		PH_COUNT_LF = 4'd2,
		PH_ELEM     = 4'd3,
		PH_LEN      = 4'd4,
		PH_LEN_LF   = 4'd5,
		PH_DATA     = 4'd6,
		PH_DATA_CR  = 4'd7,
		PH_DATA_LF  = 4'd8,
		PH_IDLE     = 4'd9
	} phase_t;

	typedef struct packed {
		logic [CFG_CNT_BITS-1:0] max_array_count;
		logic [CFG_LEN_BITS-1:0] max_bulk_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [7:0]              payload_byte;
		logic                    field_last;
		logic [ARG_BITS-1:0]     arg_index;
		logic [ID_BITS-1:0]      database_id;
		logic [MSG_LEN_BITS-1:0] message_length;
	} res_t;

endpackage

`default_nettype wire

/* hdl/rrp_core.sv */
// rrp_core: per-byte parser state and the result decode for one transfer
// depends on rrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrp_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   data_byte,
	input  wire logic         message_start,
	input  wire rrp_pkg::cfg_t cfg,
	output logic              res_valid,
	output rrp_pkg::res_t     res
);

	localparam int NW  = rrp_pkg::NUM_BITS + 4;
	localparam int IDW = rrp_pkg::ID_BITS + 4;
	localparam int CB  = rrp_pkg::COUNT_BITS;
	localparam int LB  = rrp_pkg::LENGTH_BITS;
	localparam int MB  = rrp_pkg::MSG_LEN_BITS;
	localparam int NB  = rrp_pkg::NUM_BITS;
	localparam int IB  = rrp_pkg::ID_BITS;

	rrp_pkg::phase_t phase_q, ph, ph_n;
	logic [CB-1:0] tot_q, tot, tot_n;
	logic [CB-1:0] idx_q, idx, idx_n;
	logic [NB-1:0] acc_q, acc, acc_n;
	logic          seen_q, seen, seen_n;
	logic [LB-1:0] rem_q, rem, rem_n;
	logic [IB-1:0] id_q, id, id_n;
	logic [MB-1:0] cnt_q, cnt, cnt_n;

	logic [NB-1:0]  cnt_lim, len_lim, lim;
	logic [3:0]     dval;
	logic           digit;
	logic [NW-1:0]  acc10;
	logic [IDW-1:0] id10;
	logic           acc_ovf, id_ovf;
	logic [CB:0]    idx_p1;
	logic           is_id, last_byte, do_fail, do_done;
	logic [MB-1:0]  msg_len;

	always_comb begin
		cnt_lim = (NB'(cfg.max_array_count) > rrp_pkg::COUNT_MAX) ?
			rrp_pkg::COUNT_MAX : NB'(cfg.max_array_count);
		len_lim = (NB'(cfg.max_bulk_length) > rrp_pkg::LENGTH_MAX) ?
			rrp_pkg::LENGTH_MAX : NB'(cfg.max_bulk_length);

		// message start clears the parser before this byte is parsed
		if (message_start) begin
			ph   = rrp_pkg::PH_STAR;
			tot  = '0;
			idx  = '0;
			acc  = '0;
			seen = 1'b0;
			rem  = '0;
			id   = '0;
			cnt  = '0;
		end else begin
			ph   = phase_q;
			tot  = tot_q;
			idx  = idx_q;
			acc  = acc_q;
			seen = seen_q;
			rem  = rem_q;
			id   = id_q;
			cnt  = cnt_q;
		end

		digit  = (data_byte >= rrp_pkg::CH_ZERO) && (data_byte <= rrp_pkg::CH_NINE);
		dval   = 4'(data_byte - rrp_pkg::CH_ZERO);
		lim    = (ph == rrp_pkg::PH_COUNT) ? cnt_lim : len_lim;
		acc10  = (NW'(acc) << 3) + (NW'(acc) << 1) + NW'(dval);
		acc_ovf = acc10 > NW'(lim);
		id10   = (IDW'(id) << 3) + (IDW'(id) << 1) + IDW'(dval);
		id_ovf = id10 > IDW'(rrp_pkg::ID_MAX);
		idx_p1 = {1'b0, idx} + (CB+1)'(1);
		is_id  = (tot >= CB'(2)) && (idx_p1 == {1'b0, tot});
		last_byte = (rem == LB'(1));

		ph_n   = ph;
		tot_n  = tot;
		idx_n  = idx;
		acc_n  = acc;
		seen_n = seen;
		rem_n  = rem;
		id_n   = id;
		cnt_n  = cnt;
		do_fail = 1'b0;
		do_done = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (ph != rrp_pkg::PH_IDLE) begin
			cnt_n = (cnt == rrp_pkg::MSG_LEN_MAX) ? cnt : cnt + MB'(1);
			case (ph)
				rrp_pkg::PH_STAR: begin
					if (data_byte != rrp_pkg::CH_STAR) begin
						do_fail = 1'b1;
					end else begin
						acc_n  = '0;
						seen_n = 1'b0;
						ph_n   = rrp_pkg::PH_COUNT;
					end
				end
				rrp_pkg::PH_COUNT, rrp_pkg::PH_LEN: begin
					if (digit) begin
						if (acc_ovf) begin
							do_fail = 1'b1;
						end else begin
							acc_n  = NB'(acc10);
							seen_n = 1'b1;
						end
					end else if (data_byte != rrp_pkg::CH_CR || !seen) begin
						do_fail = 1'b1;
					end else begin
						ph_n = (ph == rrp_pkg::PH_COUNT) ?
							rrp_pkg::PH_COUNT_LF : rrp_pkg::PH_LEN_LF;
					end
				end
				rrp_pkg::PH_COUNT_LF: begin
					if (data_byte != rrp_pkg::CH_LF) begin
						do_fail = 1'b1;
					end else begin
						tot_n = CB'(acc);
						idx_n = '0;
						if (acc == '0) begin
							do_done = 1'b1;
						end else begin
							ph_n = rrp_pkg::PH_ELEM;
						end
					end
				end
				rrp_pkg::PH_ELEM: begin
					if (data_byte == rrp_pkg::CH_SPACE) begin
						ph_n = ph;
					end else if (data_byte != rrp_pkg::CH_DOLLAR) begin
						do_fail = 1'b1;
					end else begin
						acc_n  = '0;
						seen_n = 1'b0;
						ph_n   = rrp_pkg::PH_LEN;
					end
				end
				rrp_pkg::PH_LEN_LF: begin
					if (data_byte != rrp_pkg::CH_LF) begin
						do_fail = 1'b1;
					end else begin
						rem_n  = LB'(acc);
						seen_n = 1'b0;
						if (is_id) begin
							id_n = '0;
						end
						ph_n = (acc == '0) ? rrp_pkg::PH_DATA_CR : rrp_pkg::PH_DATA;
					end
				end
				rrp_pkg::PH_DATA: begin
					rem_n = rem - LB'(1);
					if (last_byte) begin
						ph_n = rrp_pkg::PH_DATA_CR;
					end
					if (is_id) begin
						if (!digit || id_ovf) begin
							do_fail = 1'b1;
						end else begin
							id_n   = IB'(id10);
							seen_n = 1'b1;
						end
					end else begin
						res_valid        = 1'b1;
						res.payload_byte = data_byte;
						res.field_last   = last_byte;
						if (idx == '0) begin
							res.kind = rrp_pkg::KIND_NAME;
						end else begin
							res.kind      = rrp_pkg::KIND_ARG;
							res.arg_index = rrp_pkg::ARG_BITS'(idx - CB'(1));
						end
					end
				end
				rrp_pkg::PH_DATA_CR: begin
					if (data_byte != rrp_pkg::CH_CR || (is_id && !seen)) begin
						do_fail = 1'b1;
					end else begin
						ph_n = rrp_pkg::PH_DATA_LF;
					end
				end
				rrp_pkg::PH_DATA_LF: begin
					if (data_byte != rrp_pkg::CH_LF) begin
						do_fail = 1'b1;
					end else if (idx_p1 >= {1'b0, tot}) begin
						do_done = 1'b1;
					end else begin
						idx_n = idx + CB'(1);
						ph_n  = rrp_pkg::PH_ELEM;
					end
				end
				default: begin
					ph_n = rrp_pkg::PH_IDLE;
				end
			endcase
		end

		msg_len = (cnt_n == rrp_pkg::MSG_LEN_MAX) ? cnt_n : cnt_n + MB'(1);
		if (do_fail) begin
			ph_n      = rrp_pkg::PH_IDLE;
			res_valid = 1'b1;
			res       = '0;
			res.kind  = rrp_pkg::KIND_ERROR;
		end else if (do_done) begin
			ph_n               = rrp_pkg::PH_IDLE;
			res_valid          = 1'b1;
			res                = '0;
			res.kind           = rrp_pkg::KIND_DONE;
			res.database_id    = (tot_n >= CB'(2)) ? id : '0;
			res.message_length = msg_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rrp_pkg::PH_STAR;
			tot_q   <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			rem_q   <= '0;
			id_q    <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= ph_n;
			tot_q   <= tot_n;
			idx_q   <= idx_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			rem_q   <= rem_n;
			id_q    <= id_n;
			cnt_q   <= cnt_n;
		end
	end

	// result only in phases that can produce one
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !message_start) |-> (phase_q != rrp_pkg::PH_IDLE))
		else $error("result from idle parser");

	// a result ends the request unless it is a data byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && (res.kind == rrp_pkg::KIND_ERROR ||
		res.kind == rrp_pkg::KIND_DONE)) |=> (phase_q == rrp_pkg::PH_IDLE))
		else $error("parser not idle after completion or error");

	// payload bytes are only emitted while in the data phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && (res.kind == rrp_pkg::KIND_NAME ||
		res.kind == rrp_pkg::KIND_ARG)) |-> (ph == rrp_pkg::PH_DATA))
		else $error("payload byte outside data phase");

endmodule

`default_nettype wire

/* hdl/rrp_out_buf.sv */
// rrp_out_buf: result register plus one skid entry in front of the output channel
// depends on rrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrp_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rrp_pkg::res_t push_data,
	output logic               space,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rrp_pkg::res_t      out_data
);

	logic          main_v_q, skid_v_q;
	rrp_pkg::res_t main_q, skid_q;
	logic          pop;

	assign pop       = main_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (!main_v_q) begin
			main_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (!main_v_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> main_v_q)
		else $error("skid entry without head entry");

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !skid_v_q)
		else $error("push into full buffer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && !out_ready) |=> (main_v_q && $stable(main_q)))
		else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

/* hdl/resp_request_parser_unit.sv */
// resp_request_parser_unit: top level, apb registers, parser core and output buffer
// depends on rrp_pkg, rrp_core, rrp_out_buf
//
// channel  | handshake            | payload
// in       | in_valid / in_ready  | data_byte, message_start
// out      | out_valid / out_ready| kind, payload_byte, field_last, arg_index,
//          |                      | database_id, message_length
// cfg      | apb psel / penable   | paddr, pwdata, prdata (0x0 max count, 0x4 max length)
//
// one byte per cycle while in_ready is high; each input transfer is parsed in the cycle
// it is taken; at most one result per byte, registered, visible the cycle after the
// transfer unless the result register still holds a stalled result; a one-entry skid
// behind it takes that result, and in_ready drops only while both output entries are full
// asynchronous reset to the wait-for-array-marker phase, limits at maximum
`timescale 1ns / 1ps
`default_nettype none

module resp_request_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        message_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic             field_last,
	output logic [rrp_pkg::ARG_BITS-1:0]     arg_index,
	output logic [rrp_pkg::ID_BITS-1:0]      database_id,
	output logic [rrp_pkg::MSG_LEN_BITS-1:0] message_length,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	rrp_pkg::cfg_t cfg_q;
	rrp_pkg::res_t core_res, buf_res;
	logic          core_valid, accept, space;

	assign pready = 1'b1;
	assign accept = in_valid && in_ready;
	assign in_ready = space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_array_count <= '1;
			cfg_q.max_bulk_length <= '1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				rrp_pkg::REG_MAX_COUNT: begin
					cfg_q.max_array_count <= pwdata[rrp_pkg::CFG_CNT_BITS-1:0];
				end
				rrp_pkg::REG_MAX_LENGTH: begin
					cfg_q.max_bulk_length <= pwdata[rrp_pkg::CFG_LEN_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rrp_pkg::REG_MAX_COUNT:  prdata = 32'(cfg_q.max_array_count);
			rrp_pkg::REG_MAX_LENGTH: prdata = 32'(cfg_q.max_bulk_length);
			default:                 prdata = '0;
		endcase
	end

	rrp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.message_start (message_start),
		.cfg           (cfg_q),
		.res_valid     (core_valid),
		.res           (core_res)
	);

	rrp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && core_valid),
		.push_data (core_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (buf_res)
	);

	assign kind           = buf_res.kind;
	assign payload_byte   = buf_res.payload_byte;
	assign field_last     = buf_res.field_last;
	assign arg_index      = buf_res.arg_index;
	assign database_id    = buf_res.database_id;
	assign message_length = buf_res.message_length;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for resp_request_parser_unit; a byte-level parser
// model predicts every result and the output channel is compared in order
// depends on rrp_pkg and the rtl under hdl

module testbench;
	import rrp_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES  = 30;
	localparam logic [2:0] ADDR_MAX_COUNT  = {REG_MAX_COUNT, 2'b00};
	localparam logic [2:0] ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 2'b00};

	typedef enum int {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_PERIODIC,
		READY_RARELY
	} ready_mode_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic [7:0]              data_byte     = '0;
	logic                    message_start = 1'b0;
	logic                    out_ready     = 1'b0;
	logic                    psel          = 1'b0;
	logic                    penable       = 1'b0;
	logic                    pwrite        = 1'b0;
	logic [2:0]              paddr         = '0;
	logic [31:0]             pwdata        = '0;
	logic                    in_ready;
	logic                    out_valid;
	logic [1:0]              kind;
	logic [7:0]              payload_byte;
	logic                    field_last;
	logic [ARG_BITS-1:0]     arg_index;
	logic [ID_BITS-1:0]      database_id;
	logic [MSG_LEN_BITS-1:0] message_length;
	logic [31:0]             prdata;
	logic                    pready;

	resp_request_parser_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.message_start(message_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.field_last(field_last),
		.arg_index(arg_index),
		.database_id(database_id),
		.message_length(message_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// parser model state
	logic [CFG_CNT_BITS-1:0] limit_count  = '1;
	logic [CFG_LEN_BITS-1:0] limit_length = '1;
	phase_t                  parse_phase  = PH_STAR;
	logic [COUNT_BITS-1:0]   elem_total   = '0;
	logic [COUNT_BITS-1:0]   elem_index   = '0;
	logic [31:0]             number_value = '0;
	logic                    digits_seen  = 1'b0;
	logic [LENGTH_BITS-1:0]  bytes_left   = '0;
	logic [ID_BITS-1:0]      id_value     = '0;
	logic [MSG_LEN_BITS-1:0] byte_count   = '0;
	res_t                    expected_results[$];

	int          error_count = 0;
	int          idle_cycles = 0;
	ready_mode_t ready_mode  = READY_ALWAYS;
	int          ready_phase = 0;
	logic        gaps_on     = 1'b0;
	int          burst_left  = 0;
	logic [7:0]  request_bytes[$];

	function automatic string crlf_line(string s);
		return {s, "\015\012"};
	endfunction

	function automatic void append_request_byte(logic [7:0] b);
		request_bytes = {request_bytes, b};
	endfunction

	function automatic void restart_parser();
		parse_phase  = PH_STAR;
		elem_total   = '0;
		elem_index   = '0;
		number_value = '0;
		digits_seen  = 1'b0;
		bytes_left   = '0;
		id_value     = '0;
		byte_count   = '0;
	endfunction

	function automatic res_t framing_error();
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		parse_phase = PH_IDLE;
		return r;
	endfunction

	function automatic res_t request_done();
		res_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.database_id = (elem_total >= 2) ? id_value : '0;
		r.message_length = (byte_count == MSG_LEN_MAX) ? MSG_LEN_MAX : byte_count + 1'b1;
		parse_phase = PH_IDLE;
		return r;
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic start);
		res_t        r;
		logic        produced;
		logic        is_digit;
		logic        id_elem;
		logic        last;
		logic [63:0] cap_count;
		logic [63:0] cap_length;
		logic [63:0] v;
		r = '0;
		produced = 1'b0;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		cap_count = (64'(limit_count) < 64'(COUNT_MAX)) ? 64'(limit_count) : 64'(COUNT_MAX);
		cap_length = (64'(limit_length) < 64'(LENGTH_MAX)) ? 64'(limit_length) :
			64'(LENGTH_MAX);
		if (start)
			restart_parser();
		if (parse_phase == PH_IDLE)
			return;
		if (byte_count != MSG_LEN_MAX)
			byte_count = byte_count + 1'b1;
		id_elem = (elem_total >= 2) && (9'(elem_index) + 9'd1 == 9'(elem_total));
		v = 64'(number_value) * 10 + 64'(b - CH_ZERO);
		case (parse_phase)
			PH_STAR: begin
				if (b != CH_STAR) begin
					r = framing_error();
					produced = 1'b1;
				end else begin
					number_value = '0;
					digits_seen = 1'b0;
					parse_phase = PH_COUNT;
				end
			end
			PH_COUNT, PH_LEN: begin
				if (is_digit) begin
					if (v > ((parse_phase == PH_COUNT) ? cap_count : cap_length)) begin
						r = framing_error();
						produced = 1'b1;
					end else begin
						number_value = v[31:0];
						digits_seen = 1'b1;
					end
				end else if (b != CH_CR || !digits_seen) begin
					r = framing_error();
					produced = 1'b1;
				end else begin
					parse_phase = (parse_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
				end
			end
			PH_COUNT_LF: begin
				if (b != CH_LF) begin
					r = framing_error();
					produced = 1'b1;
				end else begin
					elem_total = number_value[COUNT_BITS-1:0];
					elem_index = '0;
					if (elem_total == 0) begin
						r = request_done();
						produced = 1'b1;
					end else begin
						parse_phase = PH_ELEM;
					end
				end
			end
			PH_ELEM: begin
				if (b != CH_SPACE) begin
					if (b != CH_DOLLAR) begin
						r = framing_error();
						produced = 1'b1;
					end else begin
						number_value = '0;
						digits_seen = 1'b0;
						parse_phase = PH_LEN;
					end
				end
			end
			PH_LEN_LF: begin
				if (b != CH_LF) begin
					r = framing_error();
					produced = 1'b1;
				end else begin
					bytes_left = number_value[LENGTH_BITS-1:0];
					digits_seen = 1'b0;
					if (id_elem)
						id_value = '0;
					parse_phase = (bytes_left == 0) ? PH_DATA_CR : PH_DATA;
				end
			end
			PH_DATA: begin
				last = (bytes_left == 1);
				bytes_left = bytes_left - 1'b1;
				if (last)
					parse_phase = PH_DATA_CR;
				if (id_elem) begin
					v = 64'(id_value) * 10 + 64'(b - CH_ZERO);
					if (!is_digit || v > 64'(ID_MAX)) begin
						r = framing_error();
						produced = 1'b1;
					end else begin
						id_value = v[ID_BITS-1:0];
						digits_seen = 1'b1;
					end
				end else begin
					produced = 1'b1;
					r.kind = (elem_index == 0) ? KIND_NAME : KIND_ARG;
					r.payload_byte = b;
					r.field_last = last;
					r.arg_index = (elem_index == 0) ? '0 : elem_index - 1'b1;
				end
			end
			PH_DATA_CR: begin
				if (b != CH_CR || (id_elem && !digits_seen)) begin
					r = framing_error();
					produced = 1'b1;
				end else begin
					parse_phase = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				if (b != CH_LF) begin
					r = framing_error();
					produced = 1'b1;
				end else if (9'(elem_index) + 9'd1 >= 9'(elem_total)) begin
					r = request_done();
					produced = 1'b1;
				end else begin
					elem_index = elem_index + 1'b1;
					parse_phase = PH_ELEM;
				end
			end
			default: parse_phase = PH_IDLE;
		endcase
		if (produced)
			expected_results = {expected_results, r};
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s expected 0x%0h actual 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// transfer monitor: results first, then the byte taken at the same edge
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with none expected, kind %0d", kind);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", 32'(want.kind), 32'(kind));
					compare_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
					compare_field("field_last", 32'(want.field_last), 32'(field_last));
					compare_field("arg_index", 32'(want.arg_index), 32'(arg_index));
					compare_field("database_id", 32'(want.database_id), 32'(database_id));
					compare_field("message_length", 32'(want.message_length),
						32'(message_length));
				end
			end
			if (in_valid && in_ready)
				parse_byte(data_byte, message_start);
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_MAX_COUNT)
					limit_count = pwdata[CFG_CNT_BITS-1:0];
				else if (paddr == ADDR_MAX_LENGTH)
					limit_length = pwdata[CFG_LEN_BITS-1:0];
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL resp_request_parser_unit");
			$finish;
		end
	end

	always @(negedge clk) begin
		ready_phase <= (ready_phase + 1) % 11;
		case (ready_mode)
			READY_ALWAYS:   out_ready <= 1'b1;
			READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
			READY_PERIODIC: out_ready <= (ready_phase > 4);
			default:        out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_byte(logic [7:0] b, logic start);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		data_byte <= b;
		message_start <= start;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_text(string s, logic start);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], start && (i == 0));
	endtask

	task automatic send_request(logic start);
		for (int i = 0; i < request_bytes.size(); i++)
			send_byte(request_bytes[i], start && (i == 0));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic cfg_read(logic [2:0] addr, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_limits();
		logic [31:0] rd;
		cfg_read(ADDR_MAX_COUNT, rd);
		compare_field("max_array_count", 32'(limit_count), rd);
		cfg_read(ADDR_MAX_LENGTH, rd);
		compare_field("max_bulk_length", 32'(limit_length), rd);
	endtask

	// upper bits are random and must be dropped by the registers
	task automatic set_limits(logic [7:0] count, logic [15:0] length);
		wait_drained();
		cfg_write(ADDR_MAX_COUNT, ($urandom & 32'hFFFF_FF00) | 32'(count));
		cfg_write(ADDR_MAX_LENGTH, ($urandom & 32'hFFFF_0000) | 32'(length));
		check_limits();
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			append_request_byte(s[i]);
	endtask

	task automatic build_request(int count, int max_len);
		int          len;
		logic [31:0] id;
		string       digits;
		request_bytes.delete();
		push_text(crlf_line($sformatf("*%0d", count)));
		for (int e = 0; e < count; e++) begin
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
				append_request_byte(CH_SPACE);
			if (count >= 2 && e == count - 1) begin
				case ($urandom_range(0, 7))
					0:       id = 32'h7FFF_FFFF;
					1:       id = $urandom;
					2:       id = 32'd0;
					default: id = $urandom_range(0, 99999);
				endcase
				digits = $sformatf("%0d", id);
				push_text(crlf_line($sformatf("$%0d", digits.len())));
				push_text(crlf_line(digits));
			end else begin
				len = $urandom_range(0, max_len);
				push_text(crlf_line($sformatf("$%0d", len)));
				repeat (len) append_request_byte(8'($urandom_range(0, 255)));
				push_text(crlf_line(""));
			end
		end
	endtask

	task automatic test_register_defaults();
		check_limits();
	endtask

	task automatic test_framing();
		gaps_on = 1'b0;
		ready_mode = READY_ALWAYS;
		// out of reset the parser already waits for the array marker
		send_text({crlf_line("*1"), crlf_line("$3"), crlf_line("GET")}, 1'b0);
		send_text("xyz*", 1'b0);
		send_text(crlf_line("*0"), 1'b1);
		send_text({crlf_line("*2"), crlf_line("$6"), crlf_line("SELECT"), crlf_line("$2"),
			crlf_line("15")}, 1'b1);
		send_text({crlf_line("*5"), crlf_line("$3"), crlf_line("SET"), "  ", crlf_line("$1"),
			crlf_line("k"), " ", crlf_line("$0"), crlf_line(""), crlf_line("$2"),
			crlf_line("vv"), crlf_line("$10"), crlf_line("2147483647")}, 1'b1);
		send_text({crlf_line("*1"), crlf_line("$4")}, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text(crlf_line(""), 1'b0);
		gaps_on = 1'b1;
		ready_mode = READY_RARELY;
		send_text({crlf_line("*2"), crlf_line("$1"), crlf_line("A"), crlf_line("$10"),
			crlf_line("2147483648")}, 1'b1);
		send_text({crlf_line("*2"), crlf_line("$1"), crlf_line("A"), crlf_line("$2"), "1a"},
			1'b1);
		send_text({crlf_line("*2"), crlf_line("$1"), crlf_line("A"), crlf_line("$0"),
			crlf_line("")}, 1'b1);
		send_text(crlf_line("*"), 1'b1);
		send_text("*-1", 1'b1);
		send_text("*1 ", 1'b1);
		send_text("X", 1'b1);
		send_text({crlf_line("*1"), crlf_line("$1"), "A\012"}, 1'b1);
		send_text({crlf_line("*1"), crlf_line("$1"), "A\015X"}, 1'b1);
		send_text("*1\015X", 1'b1);
		send_text({crlf_line("*1"), "#"}, 1'b1);
		send_text({crlf_line("*1"), crlf_line("$")}, 1'b1);
		send_text({crlf_line("*1"), "$1x"}, 1'b1);
		send_text({crlf_line("*255"), crlf_line("$0"), crlf_line("")}, 1'b1);
		send_text("*256", 1'b1);
		send_text({crlf_line("*01"), crlf_line("$65535")}, 1'b1);
		send_text({crlf_line("*1"), "$65536"}, 1'b1);
		wait_drained();
	endtask

	task automatic test_limits();
		gaps_on = 1'b1;
		ready_mode = READY_MOSTLY;
		set_limits(8'd2, 16'd3);
		send_text("*3", 1'b1);
		send_text({crlf_line("*2"), "$4"}, 1'b1);
		send_text({crlf_line("*2"), crlf_line("$3"), crlf_line("abc"), crlf_line("$1"),
			crlf_line("7")}, 1'b1);
		set_limits(8'd0, 16'd0);
		send_text(crlf_line("*0"), 1'b1);
		send_text("*1", 1'b1);
		set_limits(8'd255, 16'd0);
		send_text({crlf_line("*1"), crlf_line("$0"), crlf_line("")}, 1'b1);
		send_text({crlf_line("*1"), "$1"}, 1'b1);
		set_limits(8'd255, 16'd65535);
	endtask

	task automatic test_max_elements();
		gaps_on = 1'b1;
		ready_mode = READY_PERIODIC;
		build_request(12, 2);
		send_request(1'b1);
		wait_drained();
	endtask

	task automatic test_random();
		int sent;
		int count;
		int cut;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       set_limits(8'd255, 16'd65535);
				1:       set_limits(8'($urandom_range(3, 8)), 16'($urandom_range(2, 10)));
				2:       set_limits(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)));
				default: set_limits(8'd255, 16'd65535);
			endcase
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
				build_request(count, ($urandom_range(0, 7) == 0) ? 40 : 4);
				case ($urandom_range(0, 9))
					0: request_bytes[$urandom_range(0, request_bytes.size() - 1)] =
						8'($urandom_range(0, 255));
					1: begin
						cut = $urandom_range(1, request_bytes.size());
						while (request_bytes.size() > cut)
							void'(request_bytes.pop_back());
					end
					default: ;
				endcase
				sent += request_bytes.size();
				send_request($urandom_range(0, 15) != 0);
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 24) == 0)
					wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_defaults();
		test_framing();
		test_limits();
		test_max_elements();
		test_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("PASS resp_request_parser_unit");
		else
			$display("FAIL resp_request_parser_unit");
		$finish;
	end

endmodule

/* sim.f */
hdl/rrp_pkg.sv
hdl/rrp_core.sv
hdl/rrp_out_buf.sv
hdl/resp_request_parser_unit.sv
verif/testbench.sv
